@@ hw/rtl/cdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked transfer deframer package
// Beat types, phase and status codes, and byte classification helpers.
// ----------------------------------------------------------------------------
package cdf_pkg;

    // Width of the chunk size accumulator and the data byte counter
    localparam int SIZE_BITS = 32;

    // Bytes skipped after the data of each chunk
    localparam int TRAIL_BYTES = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Decoder phase, one-hot
    typedef enum logic [6:0] {
        PH_WS     = 7'b0000001,
        PH_DIGITS = 7'b0000010,
        PH_REST   = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_TRAIL  = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_ERROR  = 7'b1000000
    } t_phase;

    // End-of-stream status codes
    typedef enum logic [2:0] {
        ST_TERMINATED = 3'd0,
        ST_BETWEEN    = 3'd1,
        ST_TRUNCATED  = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_OVERFLOW   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_mark;
        logic [2:0] status;
    } t_out_beat;

    // Whitespace: space, HT, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    // Nibble value of a hex digit; meaningless for other bytes
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [3:0] v;
        if (b <= 8'h39) begin
            v = b[3:0];
        end else begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/cdf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked transfer deframer input channel
// Valid/ready channel carrying one raw body byte per beat.
// ----------------------------------------------------------------------------
interface cdf_in_if import cdf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/cdf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked transfer deframer output channel
// Valid/ready channel carrying one decoded byte or end status per beat.
// ----------------------------------------------------------------------------
interface cdf_out_if import cdf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/chunked_transfer_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked transfer deframer
// A result beat appears in the output register in the cycle after its input
// beat is taken. Throughput: one byte per cycle, set by the single
// phase/counter update done on each accepted beat; stalls only when the
// output register is full and not being drained. Synchronous active-low
// reset returns the decoder to the start of a size line with no result held.
// ----------------------------------------------------------------------------
module chunked_transfer_deframer import cdf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdf_in_if.sink    i_in,
    cdf_out_if.source o_out
);

    t_phase               r_phase,     n_phase;
    logic [SIZE_BITS-1:0] r_remaining, n_remaining;
    logic [SIZE_BITS-1:0] r_acc,       n_acc;
    logic                 r_digits,    n_digits;
    logic                 r_cr,        n_cr;
    t_status              r_sticky,    n_sticky;

    logic                 r_out_valid;
    t_out_beat            r_out;

    logic                 in_acc;
    logic [7:0]           b;
    logic                 res_emit;
    logic                 res_valid;
    t_status              res_status;

    // Take a beat whenever the output register is free or being drained
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign b           = i_in.data.in_byte;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Advance the decoder by one byte
    always_comb begin
        n_phase     = r_phase;
        n_remaining = r_remaining;
        n_acc       = r_acc;
        n_digits    = r_digits;
        n_cr        = r_cr;
        n_sticky    = r_sticky;
        res_valid   = 1'b0;
        res_status  = ST_TERMINATED;
        res_emit    = 1'b0;

        if (in_acc) begin
            unique case (r_phase)
                PH_WS, PH_DIGITS, PH_REST: begin
                    if (r_cr && (b == CHAR_LF)) begin
                        // End of size line
                        n_cr = 1'b0;
                        priority if (!r_digits) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ST_BAD_SIZE;
                        end else if (r_acc == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_remaining = r_acc;
                            n_phase     = PH_DATA;
                        end
                    end else begin
                        n_cr = (b == CHAR_CR);
                        priority if (r_phase == PH_REST) begin
                            // drop extension bytes
                        end else if ((r_phase == PH_WS) && is_space(b)) begin
                            // skip leading whitespace
                        end else if (!is_hex(b)) begin
                            n_phase = PH_REST;
                        end else if (r_acc[SIZE_BITS-1 -: 4] != 4'd0) begin
                            n_phase  = PH_ERROR;
                            n_sticky = ST_OVERFLOW;
                        end else begin
                            n_acc    = {r_acc[SIZE_BITS-5:0], hex_nibble(b)};
                            n_digits = 1'b1;
                            n_phase  = PH_DIGITS;
                        end
                    end
                end
                PH_DATA: begin
                    res_valid = 1'b1;
                    if (r_remaining == SIZE_BITS'(1)) begin
                        n_remaining = SIZE_BITS'(TRAIL_BYTES);
                        n_phase     = PH_TRAIL;
                    end else begin
                        n_remaining = r_remaining - SIZE_BITS'(1);
                    end
                end
                PH_TRAIL: begin
                    if (r_remaining == SIZE_BITS'(1)) begin
                        n_remaining = '0;
                        n_phase     = PH_WS;
                        n_acc       = '0;
                        n_digits    = 1'b0;
                        n_cr        = 1'b0;
                    end else begin
                        n_remaining = r_remaining - SIZE_BITS'(1);
                    end
                end
                default: begin
                    // terminated or failed: ignore the byte
                end
            endcase

            res_emit = res_valid || i_in.data.last_byte;

            // Report status and restart on the final byte
            if (i_in.data.last_byte) begin
                unique case (n_phase)
                    PH_ERROR: res_status = n_sticky;
                    PH_DONE:  res_status = ST_TERMINATED;
                    PH_DATA:  res_status = ST_TRUNCATED;
                    default:  res_status = ST_BETWEEN;
                endcase
                n_phase     = PH_WS;
                n_remaining = '0;
                n_acc       = '0;
                n_digits    = 1'b0;
                n_cr        = 1'b0;
                n_sticky    = ST_TERMINATED;
            end
        end
    end

    // Hold decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_remaining <= '0;
            r_acc       <= '0;
            r_digits    <= 1'b0;
            r_cr        <= 1'b0;
            r_sticky    <= ST_TERMINATED;
        end else begin
            r_phase     <= n_phase;
            r_remaining <= n_remaining;
            r_acc       <= n_acc;
            r_digits    <= n_digits;
            r_cr        <= n_cr;
            r_sticky    <= n_sticky;
        end
    end

    // Load the result register, drop the beat once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out.out_byte   <= res_valid ? b : 8'h00;
            r_out.byte_valid <= res_valid;
            r_out.end_mark   <= i_in.data.last_byte;
            r_out.status     <= res_status;
        end
    end

    // A result without data must be an end beat with a zero byte
    a_nodata_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.byte_valid) |-> (r_out.end_mark && (r_out.out_byte == 8'h00)))
        else $error("result beat with neither data nor end mark");

    // Status is only carried on end beats
    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.end_mark) |-> (r_out.status == ST_TERMINATED))
        else $error("status set on a non-final beat");

    // The data counter never sits at zero while passing data
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_remaining != '0))
        else $error("data phase with zero remaining count");

    // A final byte restarts the decoder at a fresh size line
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.data.last_byte) |=>
            ((r_phase == PH_WS) && (r_acc == '0) && !r_digits && !r_cr))
        else $error("decoder not restarted after final byte");

endmodule

@@ bench/chunked_transfer_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked transfer deframer testbench
// Feeds raw chunked bodies through the valid/ready input one byte per beat:
// first a short table of hand-made cases, then random bodies. Most of the
// random bodies are well formed, and some are cut short, carry bad or
// overflowing size lines, or are plain noise. A behavioural decoder
// predicts each result beat, and every beat taken from the output is checked
// field by field against the oldest prediction. Both sides idle at random,
// and the sink holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module chunked_transfer_deframer_tb;
    import cdf_pkg::*;

    localparam int ITEMS = 600;

    // One byte of stimulus; typed rows carry their result beat written out
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
        logic       typed;
        t_out_beat  want;
    } t_feed_row;

    localparam t_out_beat NO_BEAT = '0;

    // Directed cases, walked in order before the random bodies
    t_feed_row directed_rows [25] = '{
        // size three with a lone CR inside the line, cut after two data bytes
        '{" ",     1'b0, 1'b0, NO_BEAT},
        '{"3",     1'b0, 1'b0, NO_BEAT},
        '{CHAR_CR, 1'b0, 1'b0, NO_BEAT},
        '{";",     1'b0, 1'b0, NO_BEAT},
        '{CHAR_CR, 1'b0, 1'b0, NO_BEAT},
        '{CHAR_LF, 1'b0, 1'b0, NO_BEAT},
        '{8'h00,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ST_TERMINATED}},
        '{8'hFF,   1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, ST_TRUNCATED}},
        // one-byte chunk, stream stops inside the skipped trailer
        '{"1",     1'b0, 1'b0, NO_BEAT},
        '{CHAR_CR, 1'b0, 1'b0, NO_BEAT},
        '{CHAR_LF, 1'b0, 1'b0, NO_BEAT},
        '{"A",     1'b0, 1'b1, '{"A", 1'b1, 1'b0, ST_TERMINATED}},
        '{CHAR_CR, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BETWEEN}},
        // size line with no digits, then a byte past the error
        '{CHAR_CR, 1'b0, 1'b0, NO_BEAT},
        '{CHAR_LF, 1'b0, 1'b0, NO_BEAT},
        '{"Z",     1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_BAD_SIZE}},
        // nine significant digits overflow the size
        '{"f",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"F",     1'b0, 1'b0, NO_BEAT},
        '{"0",     1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVERFLOW}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdf_in_if  in_ch ();
    cdf_out_if out_ch ();

    chunked_transfer_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // Decoder state of the prediction
    t_phase               dec_phase;
    t_status              dec_sticky;
    logic [SIZE_BITS-1:0] dec_left;
    logic [SIZE_BITS-1:0] dec_size;
    logic                 dec_digits;
    logic                 dec_cr;

    t_feed_row  feed_q [$];
    t_out_beat  decoded_fifo [$];
    logic [7:0] body [$];

    int live_bytes   = 0;
    int bytes_sent   = 0;
    int bodies_sent  = 0;
    int results_seen = 0;
    int errors       = 0;
    int status_seen [8] = '{default: 0};

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int digit_value(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic logic blank_byte(input logic [7:0] b);
        return (b == " ") || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    task automatic open_size_line();
        dec_phase  = PH_WS;
        dec_size   = '0;
        dec_digits = 1'b0;
        dec_cr     = 1'b0;
    endtask

    task automatic reset_decoder();
        open_size_line();
        dec_left   = '0;
        dec_sticky = ST_TERMINATED;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output logic produced, output t_out_beat res);
        logic    data_beat;
        int      nib;
        t_status st;
        data_beat = 1'b0;
        st        = ST_TERMINATED;
        case (dec_phase)
            PH_WS, PH_DIGITS, PH_REST: begin
                if (dec_cr && b == CHAR_LF) begin
                    // close the size line and act on what it held
                    dec_cr = 1'b0;
                    if (!dec_digits) begin
                        dec_phase  = PH_ERROR;
                        dec_sticky = ST_BAD_SIZE;
                    end else if (dec_size == 0) begin
                        dec_phase = PH_DONE;
                    end else begin
                        dec_left  = dec_size;
                        dec_phase = PH_DATA;
                    end
                end else begin
                    dec_cr = (b == CHAR_CR);
                    if (dec_phase == PH_WS && !blank_byte(b)) dec_phase = PH_DIGITS;
                    if (dec_phase == PH_DIGITS) begin
                        nib = digit_value(b);
                        if (nib < 0) begin
                            dec_phase = PH_REST;
                        end else if (dec_size[SIZE_BITS-1 -: 4] != 0) begin
                            dec_phase  = PH_ERROR;
                            dec_sticky = ST_OVERFLOW;
                        end else begin
                            dec_size   = {dec_size[SIZE_BITS-5:0], 4'(nib)};
                            dec_digits = 1'b1;
                        end
                    end
                end
            end
            PH_DATA: begin
                // pass the byte, then skip the trailer once the chunk is spent
                data_beat = 1'b1;
                if (dec_left != 0) dec_left = dec_left - SIZE_BITS'(1);
                if (dec_left == 0) begin
                    dec_left  = SIZE_BITS'(TRAIL_BYTES);
                    dec_phase = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                if (dec_left != 0) dec_left = dec_left - SIZE_BITS'(1);
                if (dec_left == 0) open_size_line();
            end
            default: begin
            end
        endcase

        if (last) begin
            case (dec_phase)
                PH_ERROR: st = dec_sticky;
                PH_DONE:  st = ST_TERMINATED;
                PH_DATA:  st = ST_TRUNCATED;
                default:  st = ST_BETWEEN;
            endcase
        end
        produced       = data_beat | last;
        res.out_byte   = data_beat ? b : 8'h00;
        res.byte_valid = data_beat;
        res.end_mark   = last;
        res.status     = st;
        if (last) reset_decoder();
    endtask

    // ------------------------------------------------------------------------
    // Random bodies
    // ------------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
    endfunction

    // Size line with random leading blanks, leading zeros and extension
    task automatic put_size_line(input logic [SIZE_BITS-1:0] size);
        logic [7:0] c;
        logic [7:0] prev;
        int         nd;
        int         k;
        prev = 8'h00;
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
                0:       c = " ";
                1:       c = 8'h09;
                2:       c = CHAR_LF;
                3:       c = 8'h0B;
                4:       c = 8'h0C;
                default: c = CHAR_CR;
            endcase
            // keep a blank CR from closing the line early
            if (prev == CHAR_CR && c == CHAR_LF) c = " ";
            body.push_back(c);
            prev = c;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) body.push_back("0");
        end
        nd = 1;
        while (nd < SIZE_BITS / 4 && (size >> (4 * nd)) != 0) nd++;
        for (k = nd - 1; k >= 0; k--) body.push_back(hex_char(size[4*k +: 4]));
        case ($urandom_range(0, 5))
            0: begin
                body.push_back(";");
                repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            1: begin
                // lone CR in the line, not followed by LF
                body.push_back(CHAR_CR);
                body.push_back(8'($urandom_range(8'h21, 8'h7E)));
            end
            default: begin
            end
        endcase
        body.push_back(CHAR_CR);
        body.push_back(CHAR_LF);
    endtask

    task automatic compose_body();
        int                   kind;
        int                   cut;
        int                   useful;
        int                   k;
        logic [SIZE_BITS-1:0] sz;
        body.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            // well-formed: a few chunks and the closing zero line
            repeat ($urandom_range(1, 3)) begin
                sz = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(1, 12);
                put_size_line(sz);
                repeat (sz) body.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) begin
                    // trailer goes unchecked, so any two bytes will do
                    body.push_back(8'($urandom_range(0, 255)));
                    body.push_back(8'($urandom_range(0, 255)));
                end else begin
                    body.push_back(CHAR_CR);
                    body.push_back(CHAR_LF);
                end
            end
            put_size_line('0);
        end else if (kind == 6) begin
            // size line without any digit
            repeat ($urandom_range(0, 3)) begin
                body.push_back($urandom_range(0, 1) ? " " : 8'($urandom_range("g", "z")));
            end
            body.push_back(CHAR_CR);
            body.push_back(CHAR_LF);
        end else if (kind == 7) begin
            // more significant digits than the size holds
            repeat ($urandom_range(0, 2)) body.push_back("0");
            body.push_back(hex_char(4'($urandom_range(1, 15))));
            repeat ($urandom_range(8, 10)) body.push_back(hex_char(4'($urandom_range(0, 15))));
            body.push_back(CHAR_CR);
            body.push_back(CHAR_LF);
        end else if (kind == 8) begin
            // full-width size, stream stops a few bytes into the data
            sz = $urandom;
            sz[SIZE_BITS-1 -: 4] = 4'($urandom_range(1, 15));
            put_size_line(sz);
            repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(0, 255)));
        end

        useful = body.size();
        // stray bytes after the end of decoding
        if (kind != 8) begin
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
        end
        cut = body.size() - 1;
        if (kind <= 5 && $urandom_range(0, 3) == 0) cut = $urandom_range(0, cut);
        if (cut + 1 < useful) useful = cut + 1;
        live_bytes += useful;
        for (k = 0; k <= cut; k++) feed_q.push_back('{body[k], k == cut, 1'b0, NO_BEAT});
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [7:0] exp,
                                 input logic [7:0] act);
        if (act !== exp) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp, act);
        end
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        results_seen++;
        if (decoded_fifo.size() == 0) begin
            errors++;
            $display("%0t ns: result beat with nothing expected, expected none, got %h",
                     $time, got);
            return;
        end
        want = decoded_fifo.pop_front();
        compare_field("out_byte",   want.out_byte,       got.out_byte);
        compare_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        compare_field("end_mark",   8'(want.end_mark),   8'(got.end_mark));
        compare_field("status",     8'(want.status),     8'(got.status));
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls, calm stretches and one long hold-off
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int        stall;
        logic      rx_calm;
        logic      held_off;
        t_out_beat got;
        rx_calm  = 1'b0;
        held_off = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 8);
            // hold off long enough for the input side to back up
            if (!held_off && results_seen == 120) begin
                stall    = 250;
                held_off = 1'b1;
            end
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = out_ch.data;
            check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, prediction on acceptance, and end of run
    // ------------------------------------------------------------------------
    initial begin : byte_source
        t_feed_row row;
        t_out_beat res;
        logic      produced;
        logic      tx_calm;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        tx_calm      = 1'b0;
        reset_decoder();

        foreach (directed_rows[k]) feed_q.push_back(directed_rows[k]);
        while (live_bytes < ITEMS) compose_body();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (feed_q.size() != 0) begin
            row = feed_q.pop_front();
            if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
            repeat (tx_calm ? 0 : $urandom_range(0, 8)) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            @(negedge i_clk);
            in_ch.valid <= 1'b1;
            in_ch.data  <= '{row.in_byte, row.last_byte};
            do @(posedge i_clk); while (!in_ch.ready);

            // advance the prediction on the accepted beat
            decode_byte(row.in_byte, row.last_byte, produced, res);
            if (row.typed) res = row.want;
            if (produced) decoded_fifo.push_back(res);
            if (produced && res.end_mark) begin
                status_seen[res.status]++;
                bodies_sent++;
            end
            bytes_sent++;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        // drain, then watch a little longer for stray beats
        while (decoded_fifo.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Ran %0d bodies, %0d bytes in, %0d result beats checked, %0d errors",
                 bodies_sent, bytes_sent, results_seen, errors);
        $display("End states: terminated %0d, between %0d, truncated %0d, bad size %0d, %s %0d",
                 status_seen[ST_TERMINATED], status_seen[ST_BETWEEN],
                 status_seen[ST_TRUNCATED], status_seen[ST_BAD_SIZE],
                 "overflow", status_seen[ST_OVERFLOW]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake
    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
